// File: design/uhe_pkg.sv
package uhe_pkg;
	localparam int MAX_BINS_DEF = 1024;
	localparam int DIV_STEPS = 64;

	typedef enum logic [1:0] {
		CMD_FILL    = 2'd0,
		CMD_READ    = 2'd1,
		CMD_SUMMARY = 2'd2,
		CMD_SPARE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_INT_ZERO  = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	localparam logic [1:0] REG_LOW   = 2'd0;
	localparam logic [1:0] REG_HIGH  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;
	localparam logic [1:0] REG_WIDTH = 2'd3;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
endpackage

// File: design/uhe_if.sv
interface uhe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] sample;
	logic [9:0]  bin_index;
	logic [16:0] bin_point;
	modport source (output valid, cmd, sample, bin_index, bin_point, input ready);
	modport sink (input valid, cmd, sample, bin_index, bin_point, output ready);
endinterface

interface uhe_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] bin_value;
	logic [31:0] bin_position;
	logic [31:0] normalized_value;
	logic [63:0] integral;
	logic [31:0] underflow_count;
	logic [31:0] overflow_count;
	modport source (output valid, status, bin_value, bin_position, normalized_value,
		integral, underflow_count, overflow_count, input ready);
	modport sink (input valid, status, bin_value, bin_position, normalized_value,
		integral, underflow_count, overflow_count, output ready);
endinterface

// File: design/uniform_histogram_engine.sv
// A fill runs CLASS, DIV, RD, WR, DONE; a bin read runs CLASS, RD, POSM, POSA, NDIV,
// DONE, without NDIV on a zero integral; a summary, a bad index or an out-of-range
// sample goes CLASS, DONE; one item at a time. A held result does not block accepting
// the next item, which waits in DONE until the output register is free. Bin index and
// normalized value come from a radix-2 divider, one quotient bit a cycle (33 and 64
// steps). Reset loads defaults, clears counters and all MAX_BINS bins, taking no item.
module uniform_histogram_engine #(
	parameter int MAX_BINS = uhe_pkg::MAX_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	uhe_in_if.sink      in_ch,
	uhe_out_if.source   out_ch
);
	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = $clog2(MAX_BINS + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CLASS, S_DIV, S_RD, S_WR, S_POSM, S_POSA, S_NDIV, S_DONE
	} state_t;

	state_t state_q;
	logic signed [31:0] low_q, high_q;
	logic [10:0] cnt_cfg_q;
	logic [30:0] width_q;

	logic [1:0]  cmd_q;
	logic [31:0] sample_q;
	logic [9:0]  idx_q;
	logic [16:0] point_q;

	logic [31:0] below_q, above_q, total_q;
	logic [AW-1:0] clr_q;

	logic [31:0] mem [MAX_BINS];
	logic [31:0] rdata_s1;
	logic [AW-1:0] addr_q;
	logic        we;
	logic [31:0] wdata;
	logic [AW-1:0] waddr;

	// shared restoring divider: 64-bit dividend, 64-bit divisor
	logic [63:0] dvd_q, quo_q, rem_q, dvs_q;
	logic [6:0]  step_q;
	logic [64:0] trial;

	logic [63:0] integ;
	logic [CW-1:0] nb;
	logic [31:0] bin_val_q;
	logic [57:0] frac_q;
	logic signed [43:0] pos_q;
	logic [31:0] norm_q;
	logic [2:0]  status_q;

	logic        out_valid_q;
	logic [31:0] o_bin_q, o_pos_q, o_norm_q, o_below_q, o_above_q;
	logic [63:0] o_int_q;
	logic [2:0]  o_stat_q;

	logic [26:0] scaled_idx;

	assign pready = 1'b1;
	assign integ = 64'(total_q) * 64'(width_q);

	always_comb begin
		if (cnt_cfg_q == 11'd0)
			nb = CW'(1);
		else if ({21'd0, cnt_cfg_q} > 32'(MAX_BINS))
			nb = CW'(MAX_BINS);
		else
			nb = CW'(cnt_cfg_q);
	end

	always_comb begin
		case (paddr[3:2])
			uhe_pkg::REG_LOW:   prdata = low_q;
			uhe_pkg::REG_HIGH:  prdata = high_q;
			uhe_pkg::REG_COUNT: prdata = {21'd0, cnt_cfg_q};
			default:            prdata = {1'b0, width_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q     <= '0;
			high_q    <= 32'sd1048576;
			cnt_cfg_q <= 11'd16;
			width_q   <= 31'd65536;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				uhe_pkg::REG_LOW:   low_q <= pwdata;
				uhe_pkg::REG_HIGH:  high_q <= pwdata;
				uhe_pkg::REG_COUNT: cnt_cfg_q <= pwdata[10:0];
				default:            width_q <= pwdata[30:0];
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign trial = {rem_q, dvd_q[63]} - {1'b0, dvs_q};
	assign scaled_idx = {1'b0, idx_q, 16'd0}
		+ {10'd0, (point_q > 17'd65536) ? 17'd65536 : point_q};

	// memory write port
	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = (rdata_s1 == uhe_pkg::CNT_MAX) ? rdata_s1 : rdata_s1 + 32'd1;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_WR) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			below_q     <= '0;
			above_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == 32'(MAX_BINS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						cmd_q    <= in_ch.cmd;
						sample_q <= in_ch.sample;
						idx_q    <= in_ch.bin_index;
						point_q  <= in_ch.bin_point;
						state_q  <= S_CLASS;
					end
				end
				S_CLASS: begin
					bin_val_q <= '0;
					norm_q <= '0;
					pos_q <= '0;
					if (cmd_q == uhe_pkg::CMD_FILL) begin
						if ($signed(sample_q) < low_q) begin
							if (below_q != uhe_pkg::CNT_MAX)
								below_q <= below_q + 32'd1;
							status_q <= uhe_pkg::ST_UNDERFLOW;
							state_q <= S_DONE;
						end else if ($signed(sample_q) >= high_q) begin
							if (above_q != uhe_pkg::CNT_MAX)
								above_q <= above_q + 32'd1;
							status_q <= uhe_pkg::ST_OVERFLOW;
							state_q <= S_DONE;
						end else begin
							status_q <= uhe_pkg::ST_OK;
							dvd_q <= {31'd0, 33'($signed(sample_q)) - 33'(low_q)} << 31;
							dvs_q <= {33'd0, width_q};
							rem_q <= '0;
							quo_q <= '0;
							step_q <= 7'd33;
							state_q <= S_DIV;
						end
					end else if (cmd_q == uhe_pkg::CMD_READ) begin
						if ({1'b0, idx_q} >= 11'(nb)) begin
							status_q <= uhe_pkg::ST_BAD_INDEX;
							state_q <= S_DONE;
						end else begin
							status_q <= uhe_pkg::ST_OK;
							addr_q <= AW'(idx_q);
							state_q <= S_RD;
						end
					end else begin
						status_q <= (integ == 64'd0) ? uhe_pkg::ST_INT_ZERO : uhe_pkg::ST_OK;
						state_q <= S_DONE;
					end
				end
				S_DIV, S_NDIV: begin
					if (step_q != 7'd0) begin
						if (!trial[64]) begin
							rem_q <= trial[63:0];
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], dvd_q[63]};
							quo_q <= {quo_q[62:0], 1'b0};
						end
						dvd_q <= {dvd_q[62:0], 1'b0};
						step_q <= step_q - 7'd1;
					end else if (state_q == S_DIV) begin
						// zero width gives all-ones quotient, so the clamp catches it
						if (quo_q >= 64'(nb))
							addr_q <= AW'(nb - CW'(1));
						else
							addr_q <= AW'(quo_q);
						state_q <= S_RD;
					end else begin
						norm_q <= (quo_q > {32'd0, uhe_pkg::CNT_MAX}) ? uhe_pkg::CNT_MAX
							: quo_q[31:0];
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= (cmd_q == uhe_pkg::CMD_FILL) ? S_WR : S_POSM;
				end
				S_WR: begin
					bin_val_q <= wdata;
					if (total_q != uhe_pkg::CNT_MAX)
						total_q <= total_q + 32'd1;
					state_q <= S_DONE;
				end
				S_POSM: begin
					bin_val_q <= rdata_s1;
					frac_q <= 58'(scaled_idx) * 58'(width_q);
					state_q <= S_POSA;
				end
				S_POSA: begin
					pos_q <= 44'($signed(low_q)) + $signed({2'b0, frac_q[57:16]});
					if (integ == 64'd0) begin
						status_q <= uhe_pkg::ST_INT_ZERO;
						state_q <= S_DONE;
					end else begin
						// count << 32 over the integral
						dvd_q <= {bin_val_q, 32'd0};
						rem_q <= '0;
						quo_q <= '0;
						dvs_q <= integ;
						step_q <= 7'(uhe_pkg::DIV_STEPS);
						state_q <= S_NDIV;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						o_stat_q  <= status_q;
						o_bin_q   <= bin_val_q;
						o_pos_q   <= (pos_q > 44'sd2147483647) ? 32'h7FFF_FFFF : pos_q[31:0];
						o_norm_q  <= norm_q;
						o_int_q   <= (cmd_q == uhe_pkg::CMD_FILL) ? 64'd0 : integ;
						o_below_q <= below_q;
						o_above_q <= above_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.status           = o_stat_q;
	assign out_ch.bin_value        = o_bin_q;
	assign out_ch.bin_position     = o_pos_q;
	assign out_ch.normalized_value = o_norm_q;
	assign out_ch.integral         = o_int_q;
	assign out_ch.underflow_count  = o_below_q;
	assign out_ch.overflow_count   = o_above_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == S_CLASS))
		else $error("item accepted outside idle");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ch.ready)
		else $error("ready during clearing pass");
	a_counts_mono: assert property (@(posedge clk) disable iff (!arst_n)
		below_q >= $past(below_q) && total_q >= $past(total_q))
		else $error("counter went backwards");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q)
		else $error("result dropped while stalled");
endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		uhe_pkg::cmd_t      cmd;
		logic signed [31:0] sample;
		logic [9:0]         bin_index;
		logic [16:0]        bin_point;
	} hist_item_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] bin_value;
		logic [31:0] bin_position;
		logic [31:0] normalized_value;
		logic [63:0] integral;
		logic [31:0] underflow_count;
		logic [31:0] overflow_count;
	} hist_res_t;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	uhe_in_if  in_ch ();
	uhe_out_if out_ch ();

	uniform_histogram_engine DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	// shadow of the block's registers and store
	logic signed [31:0] lo_r;
	logic signed [31:0] hi_r;
	logic [10:0]        nbins_r;
	logic [30:0]        width_r;
	logic [31:0]        bin_cnt [uhe_pkg::MAX_BINS_DEF];
	logic [31:0]        below_n;
	logic [31:0]        above_n;
	logic [31:0]        inrange_n;

	hist_item_t pending_items [$];
	hist_res_t  expected_res [$];

	int tx_idle;
	int rx_idle;
	int hold_cnt;
	bit hold_req;
	bit in_acc;
	int quiet_cycles;
	int n_fail;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == uhe_pkg::CNT_MAX) ? v : v + 32'd1;
	endfunction

	function automatic int unsigned bins_used();
		if (nbins_r == 11'd0)
			return 1;
		if (nbins_r > uhe_pkg::MAX_BINS_DEF)
			return uhe_pkg::MAX_BINS_DEF;
		return 32'(nbins_r);
	endfunction

	function automatic hist_res_t hist_predict(hist_item_t it);
		hist_res_t   r;
		longint      diff;
		longint      pos;
		logic [63:0] q;
		logic [63:0] frac;
		logic [63:0] integ;
		logic [63:0] nq;
		int unsigned nb;
		int unsigned b;
		logic [31:0] c;
		logic [16:0] pt;
		r = '{default: '0};
		nb = bins_used();
		if (it.cmd == uhe_pkg::CMD_FILL) begin
			if (it.sample < lo_r) begin
				below_n = sat_inc(below_n);
				r.status = uhe_pkg::ST_UNDERFLOW;
			end else if (it.sample >= hi_r) begin
				above_n = sat_inc(above_n);
				r.status = uhe_pkg::ST_OVERFLOW;
			end else begin
				diff = longint'(it.sample) - longint'(lo_r);
				q = (width_r == 31'd0) ? '1 : 64'(diff) / {33'b0, width_r};
				b = (q >= 64'(nb)) ? nb - 1 : 32'(q[9:0]);
				bin_cnt[b] = sat_inc(bin_cnt[b]);
				inrange_n = sat_inc(inrange_n);
				r.status = uhe_pkg::ST_OK;
				r.bin_value = bin_cnt[b];
			end
			r.underflow_count = below_n;
			r.overflow_count = above_n;
			return r;
		end
		integ = {32'b0, inrange_n} * {33'b0, width_r};
		r.integral = integ;
		r.underflow_count = below_n;
		r.overflow_count = above_n;
		if (it.cmd == uhe_pkg::CMD_READ) begin
			if (it.bin_index >= nb) begin
				r.status = uhe_pkg::ST_BAD_INDEX;
				return r;
			end
			c = bin_cnt[it.bin_index];
			pt = (it.bin_point > 17'd65536) ? 17'd65536 : it.bin_point;
			frac = (({54'b0, it.bin_index} << 16) + {47'b0, pt}) * {33'b0, width_r};
			pos = longint'(lo_r) + longint'(frac >> 16);
			if (pos > 64'sd2147483647)
				pos = 64'sd2147483647;
			r.bin_value = c;
			r.bin_position = pos[31:0];
			if (integ == 64'd0) begin
				r.status = uhe_pkg::ST_INT_ZERO;
			end else begin
				nq = {c, 32'b0} / integ;
				r.normalized_value = (nq > {32'b0, uhe_pkg::CNT_MAX}) ? uhe_pkg::CNT_MAX
					: nq[31:0];
				r.status = uhe_pkg::ST_OK;
			end
			return r;
		end
		// summary, and the spare code answered the same way
		r.status = (integ == 64'd0) ? uhe_pkg::ST_INT_ZERO : uhe_pkg::ST_OK;
		return r;
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		hist_item_t it;
		if (in_ch.valid && !in_acc) begin
			// hold the offered item
		end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
			it = pending_items.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.cmd <= it.cmd;
			in_ch.sample <= it.sample;
			in_ch.bin_index <= it.bin_index;
			in_ch.bin_point <= it.bin_point;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// receiver readiness, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		hist_item_t it;
		hist_res_t  got;
		hist_res_t  want;
		bit         any;
		any = 1'b0;
		in_acc <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready) begin
			any = 1'b1;
			it.cmd = uhe_pkg::cmd_t'(in_ch.cmd);
			it.sample = in_ch.sample;
			it.bin_index = in_ch.bin_index;
			it.bin_point = in_ch.bin_point;
			expected_res.push_back(hist_predict(it));
		end
		if (out_ch.valid && out_ch.ready) begin
			any = 1'b1;
			got.status = out_ch.status;
			got.bin_value = out_ch.bin_value;
			got.bin_position = out_ch.bin_position;
			got.normalized_value = out_ch.normalized_value;
			got.integral = out_ch.integral;
			got.underflow_count = out_ch.underflow_count;
			got.overflow_count = out_ch.overflow_count;
			if (expected_res.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result item: status %0d", got.status);
			end else begin
				want = expected_res.pop_front();
				if (got.status !== want.status || got.bin_value !== want.bin_value
						|| got.bin_position !== want.bin_position
						|| got.normalized_value !== want.normalized_value
						|| got.integral !== want.integral
						|| got.underflow_count !== want.underflow_count
						|| got.overflow_count !== want.overflow_count) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("bad result: exp st %0d val %h pos %h norm %h int %h uf %h of %h",
							want.status, want.bin_value, want.bin_position,
							want.normalized_value, want.integral,
							want.underflow_count, want.overflow_count);
						$display("            got st %0d val %h pos %h norm %h int %h uf %h of %h",
							got.status, got.bin_value, got.bin_position,
							got.normalized_value, got.integral,
							got.underflow_count, got.overflow_count);
					end
				end
			end
		end
		quiet_cycles = any ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("uniform_histogram_engine: mismatch");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			uhe_pkg::REG_LOW:   lo_r = val;
			uhe_pkg::REG_HIGH:  hi_r = val;
			uhe_pkg::REG_COUNT: nbins_r = val[10:0];
			uhe_pkg::REG_WIDTH: width_r = val[30:0];
			default: ;
		endcase
	endtask

	task automatic setup(logic [31:0] lo, logic [31:0] hi, logic [31:0] nb, logic [31:0] w);
		reg_write(uhe_pkg::REG_LOW, lo);
		reg_write(uhe_pkg::REG_HIGH, hi);
		reg_write(uhe_pkg::REG_COUNT, nb);
		reg_write(uhe_pkg::REG_WIDTH, w);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_item(uhe_pkg::cmd_t c, logic [31:0] s, logic [9:0] ix, logic [16:0] pt);
		hist_item_t it;
		it.cmd = c;
		it.sample = s;
		it.bin_index = ix;
		it.bin_point = pt;
		pending_items.push_back(it);
	endtask

	task automatic add_random(int n);
		hist_item_t  it;
		logic [63:0] span;
		int          k;
		int          sel;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			it.cmd = (k < 60) ? uhe_pkg::CMD_FILL : (k < 85) ? uhe_pkg::CMD_READ
				: (k < 95) ? uhe_pkg::CMD_SUMMARY : uhe_pkg::CMD_SPARE;
			sel = $urandom_range(0, 99);
			span = 64'(longint'(hi_r) - longint'(lo_r));
			if (sel < 70 && hi_r > lo_r)
				it.sample = lo_r + 32'({$urandom, $urandom} % span);
			else if (sel < 85)
				it.sample = $urandom;
			else
				case ($urandom_range(0, 3))
					0: it.sample = lo_r - 1;
					1: it.sample = lo_r;
					2: it.sample = hi_r - 1;
					default: it.sample = hi_r;
				endcase
			it.bin_index = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, bins_used() - 1))
				: 10'($urandom);
			it.bin_point = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, 65536))
				: 17'($urandom);
			pending_items.push_back(it);
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = uhe_pkg::CMD_FILL;
		in_ch.sample = '0;
		in_ch.bin_index = '0;
		in_ch.bin_point = '0;
		out_ch.ready = 1'b0;
		in_acc = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		quiet_cycles = 0;
		n_fail = 0;
		tx_idle = 10;
		rx_idle = 49;
		lo_r = '0;
		hi_r = 32'sd1048576;
		nbins_r = 11'd16;
		width_r = 31'd65536;
		below_n = '0;
		above_n = '0;
		inrange_n = '0;
		foreach (bin_cnt[i])
			bin_cnt[i] = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings; empty store gives a zero integral first
		add_item(uhe_pkg::CMD_SUMMARY, '0, '0, '0);
		add_item(uhe_pkg::CMD_READ, '0, '0, '0);
		add_item(uhe_pkg::CMD_READ, '0, 10'd16, '0);
		add_item(uhe_pkg::CMD_READ, '0, 10'd1023, 17'h1FFFF);
		add_item(uhe_pkg::CMD_FILL, 32'hFFFF_FFFF, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h0000_0000, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h000F_FFFF, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h0010_0000, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h7FFF_FFFF, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h8000_0000, '0, '0);
		add_item(uhe_pkg::CMD_FILL, 32'h0003_8000, '0, '0);
		add_item(uhe_pkg::CMD_READ, '0, 10'd3, 17'd65536);
		add_item(uhe_pkg::CMD_READ, '0, 10'd15, 17'h1FFFF);
		add_item(uhe_pkg::CMD_READ, '0, 10'd0, 17'd0);
		add_item(uhe_pkg::CMD_READ, '0, 10'd15, 17'd32768);
		add_item(uhe_pkg::CMD_SUMMARY, '0, '0, '0);
		add_item(uhe_pkg::CMD_SPARE, 32'hFFFF_FFFF, 10'h3FF, 17'h1FFFF);
		wait_drained();

		// full signed range, the maximum bin count
		setup(32'h8000_0000, 32'h7FFF_FFFF, 32'd1024, 32'h0040_0000);
		add_random(90);
		hold_req = 1'b1;
		add_random(100);
		wait_drained();

		// single tiny bin
		setup(32'd0, 32'd100, 32'd1, 32'd1);
		add_random(90);
		wait_drained();
		add_random(90);
		wait_drained();

		tx_idle = 49;
		rx_idle = 10;
		// zero width and zero bin count: everything lands in the only bin
		setup(32'hFFF0_0000, 32'h0010_0000, 32'd0, 32'd0);
		add_random(180);
		wait_drained();

		// inverted range, oversized bin count, widest bin
		setup(32'h0001_0000, 32'hFFFF_0000, 32'd2047, 32'h7FFF_FFFF);
		add_random(60);
		wait_drained();

		tx_idle = 0;
		rx_idle = 0;
		setup(32'hFFC0_0000, 32'h0040_0000, 32'd64, 32'h0002_0000);
		add_random(320);
		wait_drained();

		if (n_fail == 0)
			$display("uniform_histogram_engine: match");
		else
			$display("uniform_histogram_engine: mismatch");
		$finish;
	end
endmodule
